// File: rtl/kwsm_pkg.sv
// Shared constants, types and helpers for the k-way sorted stream merge.
// Used by kwsm_ctrl, kwsm_dp and k_way_sorted_stream_merge; no dependencies.
package kwsm_pkg;

  localparam int SOURCES     = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int SRC_W       = 3;
  localparam int MASK_W      = 8;
  localparam int RED_STEPS   = $clog2(SOURCES);
  localparam int STEP_W      = $clog2(RED_STEPS + 1);
  localparam logic [MASK_W-1:0] MASK_RESET = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_head;
    logic load;
    logic reduce;
    logic emit;
  } kwsm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_ok;
    logic go;
    logic out_free;
    logic chain;
  } kwsm_stat_t;

  // One candidate in the minimum search
  typedef struct packed {
    logic                          vld;
    logic [SRC_W-1:0]              idx;
    logic signed [VALUE_WIDTH-1:0] key;
  } kwsm_cand_t;

  // Keep the smaller key; on a tie keep the left (lower index) candidate
  function automatic kwsm_cand_t kwsm_pick(input kwsm_cand_t a, input kwsm_cand_t b);
    kwsm_cand_t r;
    if (!a.vld) begin
      r = b;
    end else if (!b.vld) begin
      r = a;
    end else if (b.key < a.key) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// File: rtl/kwsm_ctrl.sv
// Controller state machine for the k-way merge: sequences head write,
// readiness check, minimum search and emit. Depends on kwsm_pkg.
module kwsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  kwsm_pkg::kwsm_stat_t stat,
  output kwsm_pkg::kwsm_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [kwsm_pkg::STEP_W-1:0] step_r, step_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && stat.in_ok) begin
          cmd.wr_head = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.go) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_REDUCE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        step_nxt   = step_r + 1'b1;
        if (step_r == kwsm_pkg::STEP_W'(kwsm_pkg::RED_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.chain ? S_CHECK : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: rtl/kwsm_dp.sv
// Datapath for the k-way merge: source mask, head registers, registered
// minimum-search tree and output register. Depends on kwsm_pkg.
module kwsm_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [kwsm_pkg::MASK_W-1:0]           cfg_wr_data,
  input  logic [kwsm_pkg::SRC_W-1:0]            in_source,
  input  logic signed [kwsm_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                                  in_last,
  input  kwsm_pkg::kwsm_cmd_t                   cmd,
  output kwsm_pkg::kwsm_stat_t                  stat,
  input  logic                                  out_tready,
  output logic                                  out_valid,
  output logic signed [kwsm_pkg::VALUE_WIDTH-1:0] out_value,
  output logic [kwsm_pkg::SRC_W-1:0]            out_source,
  output logic                                  out_refill,
  output logic                                  out_done
);

  logic [kwsm_pkg::MASK_W-1:0]            mask_r;
  logic signed [kwsm_pkg::VALUE_WIDTH-1:0] head_value_r [kwsm_pkg::SOURCES];
  logic [kwsm_pkg::SOURCES-1:0]           head_valid_r, head_final_r, finished_r;
  logic [kwsm_pkg::SRC_W-1:0]             prev_r;
  kwsm_pkg::kwsm_cand_t                   cand_r [kwsm_pkg::SOURCES];
  logic                                   out_valid_r;
  logic signed [kwsm_pkg::VALUE_WIDTH-1:0] out_value_r;
  logic [kwsm_pkg::SRC_W-1:0]             out_source_r;
  logic                                   out_refill_r, out_done_r;

  logic [kwsm_pkg::SOURCES-1:0] en_vec, open_vec, sel_hot;
  logic                         prev_tie, sel_final, sel_done;
  logic [kwsm_pkg::SRC_W-1:0]   sel;

  // Merge status
  assign en_vec   = mask_r[kwsm_pkg::SOURCES-1:0];
  assign open_vec = en_vec & ~finished_r;

  assign stat.in_ok    = en_vec[in_source] & ~finished_r[in_source] & ~head_valid_r[in_source];
  assign stat.go       = (|open_vec) && ((open_vec & ~head_valid_r) == '0);
  assign stat.out_free = ~out_valid_r | out_tready;

  // Pick the winner: prefer the source emitted just before on a tie
  assign prev_tie  = en_vec[prev_r] & head_valid_r[prev_r] &
                     (head_value_r[prev_r] == cand_r[0].key);
  assign sel       = prev_tie ? prev_r : cand_r[0].idx;
  assign sel_hot   = kwsm_pkg::SOURCES'(1) << sel;
  assign sel_final = head_final_r[sel];
  assign sel_done  = sel_final && ((open_vec & ~sel_hot) == '0);
  assign stat.chain = sel_final & ~sel_done;

  // Merge state: configuration restart, head write, emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= kwsm_pkg::MASK_RESET;
      head_valid_r <= '0;
      head_final_r <= '0;
      finished_r   <= '0;
      prev_r       <= '0;
    end else if (cfg_wr_en) begin
      mask_r       <= cfg_wr_data;
      head_valid_r <= '0;
      head_final_r <= '0;
      finished_r   <= '0;
      prev_r       <= '0;
    end else begin
      if (cmd.wr_head) begin
        head_valid_r[in_source] <= 1'b1;
        head_final_r[in_source] <= in_last;
      end
      if (cmd.emit) begin
        head_valid_r[sel] <= 1'b0;
        prev_r            <= sel;
        if (sel_final) begin
          finished_r[sel]   <= 1'b1;
          head_final_r[sel] <= 1'b0;
        end
      end
    end
  end

  // Head values carry no reset
  always_ff @(posedge clk) begin
    if (cmd.wr_head) begin
      head_value_r[in_source] <= in_value;
    end
  end

  // Minimum search: load all heads, then halve the candidate row each step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < kwsm_pkg::SOURCES; i++) begin
        cand_r[i].vld <= en_vec[i] & head_valid_r[i];
        cand_r[i].idx <= kwsm_pkg::SRC_W'(i);
        cand_r[i].key <= head_value_r[i];
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < kwsm_pkg::SOURCES / 2; i++) begin
        cand_r[i] <= kwsm_pkg::kwsm_pick(cand_r[2*i], cand_r[2*i+1]);
      end
      for (int i = kwsm_pkg::SOURCES / 2; i < kwsm_pkg::SOURCES; i++) begin
        cand_r[i].vld <= 1'b0;
      end
    end
  end

  // Output register: drop valid when taken, load on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r  <= cand_r[0].key;
      out_source_r <= sel;
      out_refill_r <= ~sel_final;
      out_done_r   <= sel_done;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_source = out_source_r;
  assign out_refill = out_refill_r;
  assign out_done   = out_done_r;

endmodule

// File: rtl/k_way_sorted_stream_merge.sv
// k-way sorted stream merge: a request completing the set of heads goes through head
// write, readiness check, three registered compare levels and emit; no new request is
// taken before that emit. Each further result of a chain of finished sources repeats
// check, compares and emit; a request leaving a head missing returns to idle after the
// check, a dropped one stays idle. The emit waits while the output holds an untaken request.
// Reset (rst_n, synchronous, active low) enables all sources and clears heads; cfg restarts.
module k_way_sorted_stream_merge (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: source_mask
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] source
  input  logic        in_tlast,   // source_last
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] merged_value
  output logic [4:0]  out_tuser,  // [2:0] from_source, [3] refill_wanted, [4] merge_done
  output logic        out_tlast   // run_end
);

  kwsm_pkg::kwsm_cmd_t  cmd;
  kwsm_pkg::kwsm_stat_t stat;
  logic signed [kwsm_pkg::VALUE_WIDTH-1:0] out_value;
  logic [kwsm_pkg::SRC_W-1:0]              out_source;
  logic                                    out_refill, out_done;

  kwsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kwsm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_source   (in_tuser),
    .in_value    (in_tdata),
    .in_last     (in_tlast),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_value   (out_value),
    .out_source  (out_source),
    .out_refill  (out_refill),
    .out_done    (out_done)
  );

  // Pack the result request
  assign out_tdata = out_value;
  assign out_tuser = {out_done, out_refill, out_source};
  assign out_tlast = out_refill | out_done;

endmodule
